### hdl/epws_pkg.sv
// ----------------------------------------------------------------------------
// epws_pkg
// Shared codes and widths for the EEPROM page write sequencer.
// ----------------------------------------------------------------------------
package epws_pkg;

   // request types
   localparam logic [1:0] REQ_START   = 2'd0;
   localparam logic [1:0] REQ_TX_DONE = 2'd1;
   localparam logic [1:0] REQ_BUS_ERR = 2'd2;
   localparam logic [1:0] REQ_TICK    = 2'd3;

   // sequence phase
   localparam logic [1:0] PH_IDLE       = 2'd0;
   localparam logic [1:0] PH_WAIT_TX    = 2'd1;
   localparam logic [1:0] PH_WAIT_READY = 2'd2;

   // response status
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BUSY     = 2'd1;
   localparam logic [1:0] ST_BAD_LEN  = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BUS     = 2'd1;
   localparam logic [1:0] ERR_TIMEOUT = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_DEVICE_SELECT = 2'd0;
   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd1;
   localparam logic [1:0] CSR_READY_TIMEOUT = 2'd2;

   // register reset values
   localparam logic [2:0]  DEVICE_SELECT_RST = 3'd0;
   localparam logic [7:0]  POLL_INTERVAL_RST = 8'd1;
   localparam logic [15:0] READY_TIMEOUT_RST = 16'd20;

   localparam int ADDR_W  = 16;
   localparam int TICK_W  = 32;
   localparam int CLEN_W  = 7;

endpackage

### hdl/eeprom_page_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// eeprom_page_write_sequencer_core
// Splits an EEPROM write into page-aligned chunks and sequences them with
// readiness polling, timeout and bus-error abort.
// ----------------------------------------------------------------------------
// A request passes the input register, then the response register.
// Throughput: one request per cycle while responses are taken; the input
// and response registers let a request enter while the last response waits.
// The page offset of a start address comes from a reciprocal multiply done
// ahead of the input register.
// Reset: synchronous, clears all control state and config to reset values.
// ----------------------------------------------------------------------------
module eeprom_page_write_sequencer_core
   import epws_pkg::*;
#(
   parameter int PAGE_BYTES = 64
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wr_data,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [15:0]       req_start_addr,
   input  logic [15:0]       req_length,
   input  logic              req_device_ready,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic              rsp_issue_write,
   output logic [2:0]        rsp_write_device,
   output logic [15:0]       rsp_write_addr,
   output logic [15:0]       rsp_buffer_offset,
   output logic [6:0]        rsp_chunk_len,
   output logic              rsp_busy_res,
   output logic              rsp_done_res,
   output logic [1:0]        rsp_error_code
);

   localparam int CH_W     = $clog2(PAGE_BYTES + 1);
   localparam int SW       = CH_W + 2;
   localparam int CX_W     = CH_W + CLEN_W;
   localparam int SHIFT    = 25;
   localparam int RECIP_W  = SHIFT + 1;
   localparam int PROD_W   = ADDR_W + RECIP_W;
   localparam longint RECIP_VAL = ((64'd1 << SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
   localparam int WRAP_MOD = 65536 % PAGE_BYTES;

   localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_VAL);
   localparam logic [ADDR_W-1:0]  PAGE_A   = ADDR_W'(PAGE_BYTES);
   localparam logic [CH_W-1:0]    PAGE_C   = CH_W'(PAGE_BYTES);
   localparam logic signed [SW-1:0] PAGE_S = SW'(PAGE_BYTES);
   localparam logic signed [SW-1:0] WRAP_S = SW'(WRAP_MOD);

   // configuration
   logic [2:0]  device_select_ff;
   logic [7:0]  poll_interval_ff;
   logic [15:0] ready_timeout_ff;

   // input register
   logic               s1_valid_ff;
   logic [1:0]         s1_type_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic [ADDR_W-1:0]  s1_len_ff;
   logic               s1_ready_ff;
   logic [ADDR_W-1:0]  s1_quot_ff;
   logic [PROD_W-1:0]  quot_prod;

   // sequence state
   logic [1:0]         phase_ff, phase_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]  done_bytes_ff, done_bytes_in;
   logic [ADDR_W-1:0]  total_bytes_ff, total_bytes_in;
   logic [CH_W-1:0]    cur_chunk_ff, cur_chunk_in;
   logic [CH_W-1:0]    page_off_ff, page_off_in;
   logic [TICK_W-1:0]  tick_count_ff, tick_count_in;
   logic [TICK_W-1:0]  poll_due_ff, poll_due_in;
   logic [TICK_W-1:0]  give_up_at_ff, give_up_at_in;
   logic [1:0]         last_fault_ff, last_fault_in;

   // response register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_issue_ff, rsp_issue_in;
   logic [2:0]         rsp_device_ff, rsp_device_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [ADDR_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [CLEN_W-1:0]  rsp_clen_ff, rsp_clen_in;
   logic               rsp_done_ff, rsp_done_in;

   logic advance;
   logic req_fire;

   // datapath
   logic [ADDR_W-1:0]  quot_page;
   logic [ADDR_W-1:0]  start_rem;
   logic [TICK_W-1:0]  tick_next;
   logic [TICK_W-1:0]  poll_diff;
   logic [TICK_W-1:0]  give_diff;
   logic               poll_hit;
   logic               give_hit;
   logic [ADDR_W-1:0]  adv_done;
   logic [ADDR_W:0]    adv_addr_sum;
   logic signed [SW-1:0] off_sum;
   logic signed [SW-1:0] off_t;
   logic signed [SW-1:0] off_fix;
   logic [CH_W-1:0]    adv_off;
   logic               is_start;
   logic [ADDR_W-1:0]  iss_addr;
   logic [ADDR_W-1:0]  iss_done;
   logic [ADDR_W-1:0]  iss_total;
   logic [CH_W-1:0]    iss_off;
   logic [CH_W-1:0]    room;
   logic [ADDR_W-1:0]  left;
   logic [CH_W-1:0]    chunk;
   logic [CX_W-1:0]    chunk_ext;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // quotient of the start address by the page size, exact for 16-bit inputs
   assign quot_prod = PROD_W'(req_start_addr) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         device_select_ff <= DEVICE_SELECT_RST;
         poll_interval_ff <= POLL_INTERVAL_RST;
         ready_timeout_ff <= READY_TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEVICE_SELECT: device_select_ff <= csr_wr_data[2:0];
            CSR_POLL_INTERVAL: poll_interval_ff <= csr_wr_data[7:0];
            CSR_READY_TIMEOUT: ready_timeout_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff  <= req_type;
         s1_addr_ff  <= req_start_addr;
         s1_len_ff   <= req_length;
         s1_ready_ff <= req_device_ready;
         s1_quot_ff  <= quot_prod[SHIFT +: ADDR_W];
      end
   end

   // start path: page offset of the start address
   assign quot_page = s1_quot_ff * PAGE_A;
   assign start_rem = s1_addr_ff - quot_page;

   // tick path: wrap-safe deadline compares
   assign tick_next = tick_count_ff + TICK_W'(1);
   assign poll_diff = tick_next - poll_due_ff;
   assign give_diff = tick_next - give_up_at_ff;
   assign poll_hit  = !poll_diff[TICK_W-1];
   assign give_hit  = !give_diff[TICK_W-1];

   // advance past the confirmed chunk
   assign adv_done     = done_bytes_ff + ADDR_W'(cur_chunk_ff);
   assign adv_addr_sum = {1'b0, cur_addr_ff} + (ADDR_W+1)'(cur_chunk_ff);
   assign off_sum      = $signed(SW'(page_off_ff)) + $signed(SW'(cur_chunk_ff));

   // keep the page offset right when the address wraps past the top
   always_comb begin
      off_t = adv_addr_sum[ADDR_W] ? (off_sum - WRAP_S) : off_sum;
      if (off_t < 0) begin
         off_fix = off_t + PAGE_S;
      end else if (off_t >= PAGE_S) begin
         off_fix = off_t - PAGE_S;
      end else begin
         off_fix = off_t;
      end
   end
   assign adv_off = off_fix[CH_W-1:0];

   // chunk sizing, shared by start and next-chunk issue
   assign is_start  = (s1_type_ff == REQ_START);
   assign iss_addr  = is_start ? s1_addr_ff : adv_addr_sum[ADDR_W-1:0];
   assign iss_done  = is_start ? '0 : adv_done;
   assign iss_total = is_start ? s1_len_ff : total_bytes_ff;
   assign iss_off   = is_start ? start_rem[CH_W-1:0] : adv_off;
   assign room      = PAGE_C - iss_off;
   assign left      = iss_total - iss_done;
   assign chunk     = (left < ADDR_W'(room)) ? left[CH_W-1:0] : room;
   assign chunk_ext = CX_W'(chunk);

   always_comb begin
      phase_in       = phase_ff;
      cur_addr_in    = cur_addr_ff;
      done_bytes_in  = done_bytes_ff;
      total_bytes_in = total_bytes_ff;
      cur_chunk_in   = cur_chunk_ff;
      page_off_in    = page_off_ff;
      tick_count_in  = tick_count_ff;
      poll_due_in    = poll_due_ff;
      give_up_at_in  = give_up_at_ff;
      last_fault_in  = last_fault_ff;
      rsp_status_in  = ST_OK;
      rsp_issue_in   = 1'b0;
      rsp_done_in    = 1'b0;

      unique case (s1_type_ff)
         REQ_START: begin
            if (s1_len_ff == '0) begin
               rsp_status_in = ST_BAD_LEN;
            end else if (phase_ff == PH_WAIT_TX || phase_ff == PH_WAIT_READY) begin
               rsp_status_in = ST_BUSY;
            end else begin
               cur_addr_in    = s1_addr_ff;
               done_bytes_in  = '0;
               total_bytes_in = s1_len_ff;
               page_off_in    = iss_off;
               poll_due_in    = '0;
               give_up_at_in  = '0;
               cur_chunk_in   = chunk;
               last_fault_in  = ERR_NONE;
               phase_in       = PH_WAIT_TX;
               rsp_issue_in   = 1'b1;
            end
         end
         REQ_TX_DONE: begin
            if (phase_ff == PH_WAIT_TX) begin
               phase_in      = PH_WAIT_READY;
               poll_due_in   = tick_count_ff + TICK_W'(poll_interval_ff);
               give_up_at_in = tick_count_ff + TICK_W'(ready_timeout_ff);
            end
         end
         REQ_BUS_ERR: begin
            last_fault_in  = ERR_BUS;
            phase_in       = PH_IDLE;
            total_bytes_in = '0;
            cur_chunk_in   = '0;
         end
         default: begin
            tick_count_in = tick_next;
            if (phase_ff == PH_WAIT_READY && poll_hit) begin
               if (s1_ready_ff) begin
                  done_bytes_in = adv_done;
                  cur_addr_in   = adv_addr_sum[ADDR_W-1:0];
                  page_off_in   = adv_off;
                  if (adv_done >= total_bytes_ff) begin
                     phase_in       = PH_IDLE;
                     total_bytes_in = '0;
                     cur_chunk_in   = '0;
                     rsp_done_in    = 1'b1;
                  end else begin
                     cur_chunk_in  = chunk;
                     last_fault_in = ERR_NONE;
                     phase_in      = PH_WAIT_TX;
                     rsp_issue_in  = 1'b1;
                  end
               end else if (give_hit) begin
                  last_fault_in  = ERR_TIMEOUT;
                  phase_in       = PH_IDLE;
                  total_bytes_in = '0;
                  cur_chunk_in   = '0;
               end else begin
                  poll_due_in = tick_next + TICK_W'(poll_interval_ff);
               end
            end
         end
      endcase

      rsp_device_in = rsp_issue_in ? device_select_ff : '0;
      rsp_addr_in   = rsp_issue_in ? iss_addr : '0;
      rsp_offset_in = rsp_issue_in ? iss_done : '0;
      rsp_clen_in   = rsp_issue_in ? chunk_ext[CLEN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         cur_addr_ff    <= '0;
         done_bytes_ff  <= '0;
         total_bytes_ff <= '0;
         cur_chunk_ff   <= '0;
         page_off_ff    <= '0;
         tick_count_ff  <= '0;
         poll_due_ff    <= '0;
         give_up_at_ff  <= '0;
         last_fault_ff  <= ERR_NONE;
      end else if (advance) begin
         phase_ff       <= phase_in;
         cur_addr_ff    <= cur_addr_in;
         done_bytes_ff  <= done_bytes_in;
         total_bytes_ff <= total_bytes_in;
         cur_chunk_ff   <= cur_chunk_in;
         page_off_ff    <= page_off_in;
         tick_count_ff  <= tick_count_in;
         poll_due_ff    <= poll_due_in;
         give_up_at_ff  <= give_up_at_in;
         last_fault_ff  <= last_fault_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_issue_ff  <= rsp_issue_in;
         rsp_device_ff <= rsp_device_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_clen_ff   <= rsp_clen_in;
         rsp_done_ff   <= rsp_done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_issue_write   = rsp_issue_ff;
   assign rsp_write_device  = rsp_device_ff;
   assign rsp_write_addr    = rsp_addr_ff;
   assign rsp_buffer_offset = rsp_offset_ff;
   assign rsp_chunk_len     = rsp_clen_ff;
   assign rsp_done_res      = rsp_done_ff;
   // busy and fault reflect the state after the item that made this response
   assign rsp_busy_res      = (phase_ff == PH_WAIT_TX) || (phase_ff == PH_WAIT_READY);
   assign rsp_error_code    = last_fault_ff;

endmodule
